### rtl/core/chained_hash_table_engine_defines.svh
// Assertion macros shared by the hash table checker.
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset
`define CHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table check failed");

// Next-cycle implication, sampled on clk, quiet while in reset
`define CHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table check failed");

`endif

### rtl/core/cht_pkg.sv
// Package with sizes, request codes and stream widths of the hash table engine.
package cht_pkg;

	localparam int MAX_BUCKETS      = 1024;
	localparam int SLOTS_PER_BUCKET = 8;
	localparam int TOTAL_SLOTS      = MAX_BUCKETS * SLOTS_PER_BUCKET;

	localparam int BKT_W  = $clog2(MAX_BUCKETS);
	localparam int ADDR_W = $clog2(TOTAL_SLOTS);
	localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int BCNT_W = 11;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int KV_W   = KEY_W + VAL_W;
	localparam int DIV_STEPS = KEY_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(1024);

	// Stream widths
	localparam int S_DATA_W = KEY_W + VAL_W;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 40;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

endpackage

### rtl/core/chained_hash_table_engine.sv
// Top level of the chained hash table engine: divider, bucket fill memory and slot memory.
//
// Usage:
// Requests arrive on the s_ stream: s_tuser carries the request kind (insert, lookup,
// clear), s_tdata the key and the value. One result item per request leaves on the m_
// stream: found, read value and the bucket-full status.
// The user writes bucket_count through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce it. Zero acts as one bucket, values above 1024 as 1024.
// Timing: one item is in work at a time. The bucket index comes from a restoring
// divider, one key bit per cycle. The bucket fill memory is then read (ST_FILL,
// then ST_FCHK). An insert finishes there; a lookup scans its chain one slot at a
// time (slot memory read, then compare), over at most eight slots.
// A clear, and likewise reset, sweeps the fill memory at one bucket per cycle,
// during which no item is accepted; a clear item then gives its result.
// After reset s_tready rises only when that pass is done; the bucket count
// resets to 1024.
// The result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, a finished item holds in its last state until
// the output register is free.
module chained_hash_table_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cht_pkg::BCNT_W-1:0]     cfg_wdata,   // bucket_count
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cht_pkg::S_DATA_W-1:0]   s_tdata,     // key[31:0], entry_value[63:32]
	input  logic [cht_pkg::S_USER_W-1:0]   s_tuser,     // req_type[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cht_pkg::M_DATA_W-1:0]   m_tdata      // found[0], read_value[32:1],
	                                                    // status[33], zero[39:34]
);
	import cht_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_FILL,
		ST_FCHK,
		ST_SCAN,
		ST_SCMP,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [BCNT_W-1:0]   bucket_count_q;
	logic [BCNT_W-1:0]   div_q;
	logic [BCNT_W-1:0]   rem_q;
	logic [KEY_W-1:0]    dvd_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	req_t                req_q;
	logic [STEP_W-1:0]   step_q;
	logic [BKT_W-1:0]    clr_q;
	logic                clr_req_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   idx_q;
	logic                found_q;
	logic [VAL_W-1:0]    rv_q;
	logic                status_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic [FILL_W-1:0]   fill_mem [MAX_BUCKETS];
	logic [FILL_W-1:0]   fill_rd_q;
	logic [KV_W-1:0]     kv_mem [TOTAL_SLOTS];
	logic [KV_W-1:0]     kv_rd_q;

	logic [BKT_W-1:0]    bucket;
	logic [BCNT_W-1:0]   div_eff;
	logic [BCNT_W:0]     trial;
	logic                fill_we;
	logic [BKT_W-1:0]    fill_waddr;
	logic [FILL_W-1:0]   fill_wdata;
	logic                kv_we;
	logic [FILL_W-1:0]   slot_idx;
	logic [ADDR_W-1:0]   kv_addr;
	logic                out_free;
	logic [FILL_W-1:0]   idx_next;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Effective divisor: zero counts as one, saturate at the table size
	always_comb begin
		if (bucket_count_q == '0) begin
			div_eff = BCNT_W'(1);
		end else if (bucket_count_q > BCNT_W'(MAX_BUCKETS)) begin
			div_eff = BCNT_W'(MAX_BUCKETS);
		end else begin
			div_eff = bucket_count_q;
		end
	end

	// One restoring division step
	assign trial  = {rem_q, dvd_q[KEY_W-1]};
	assign bucket = rem_q[BKT_W-1:0];

	// Memory control: clear sweep or insert update of the fill count
	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = bucket;
		fill_wdata = fill_rd_q + FILL_W'(1);
		kv_we      = 1'b0;
		if (state_q == ST_CLEAR) begin
			fill_we    = 1'b1;
			fill_waddr = clr_q;
			fill_wdata = '0;
		end else if (state_q == ST_FCHK && req_q == REQ_INSERT &&
				fill_rd_q < FILL_W'(SLOTS_PER_BUCKET)) begin
			fill_we = 1'b1;
			kv_we   = 1'b1;
		end
	end

	// Slot address: append position on insert, scan index on lookup
	assign slot_idx = (state_q == ST_FCHK) ? fill_rd_q : idx_q;
	assign kv_addr  = ADDR_W'(bucket) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(slot_idx);
	assign idx_next = idx_q + FILL_W'(1);

	// Bucket fill memory
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rd_q <= fill_mem[bucket];
	end

	// Slot memory, key in the low half, value in the high half
	always_ff @(posedge clk) begin
		if (kv_we) begin
			kv_mem[kv_addr] <= {val_q, key_q};
		end
		kv_rd_q <= kv_mem[kv_addr];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BCNT_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_q <= s_tdata[KEY_W-1:0];
			val_q <= s_tdata[S_DATA_W-1:KEY_W];
			div_q <= div_eff;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			req_q      <= REQ_NONE;
			clr_q      <= '0;
			clr_req_q  <= 1'b0;
			step_q     <= '0;
			rem_q      <= '0;
			dvd_q      <= '0;
			fill_q     <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			rv_q       <= '0;
			status_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// Result taken; a finished item reloads the register in ST_DONE
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q    <= req_t'(s_tuser);
						found_q  <= 1'b0;
						rv_q     <= '0;
						status_q <= 1'b0;
						rem_q    <= '0;
						dvd_q    <= s_tdata[KEY_W-1:0];
						step_q   <= STEP_W'(DIV_STEPS - 1);
						case (req_t'(s_tuser))
							REQ_INSERT, REQ_LOOKUP: state_q <= ST_DIV;
							REQ_CLEAR: begin
								clr_q     <= '0;
								clr_req_q <= 1'b1;
								state_q   <= ST_CLEAR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				// Sweep every bucket count back to zero
				ST_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(MAX_BUCKETS - 1)) begin
						clr_req_q <= 1'b0;
						state_q   <= clr_req_q ? ST_DONE : ST_IDLE;
					end
				end
				// Key modulo divisor, one bit per cycle
				ST_DIV: begin
					if (trial >= {1'b0, div_q}) begin
						rem_q <= BCNT_W'(trial - {1'b0, div_q});
					end else begin
						rem_q <= trial[BCNT_W-1:0];
					end
					dvd_q  <= dvd_q << 1;
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					state_q <= ST_FCHK;
				end
				// Fill count is back: append, or start the chain scan
				ST_FCHK: begin
					fill_q <= fill_rd_q;
					idx_q  <= '0;
					if (req_q == REQ_INSERT) begin
						status_q <= (fill_rd_q >= FILL_W'(SLOTS_PER_BUCKET));
						state_q  <= ST_DONE;
					end else if (fill_rd_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					state_q <= ST_SCMP;
				end
				// Compare one stored key, stop at the first match
				ST_SCMP: begin
					idx_q <= idx_next;
					if (kv_rd_q[KEY_W-1:0] == key_q) begin
						found_q <= 1'b1;
						rv_q    <= kv_rd_q[KV_W-1:KEY_W];
						state_q <= ST_DONE;
					end else if (idx_next >= fill_q ||
							idx_next >= FILL_W'(SLOTS_PER_BUCKET)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				// Hand the result over once the output register is free
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, status_q, rv_q, found_q};
						state_q    <= ST_IDLE;
					end else begin
						m_tvalid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/cht_checker.sv
// Port-level checker for the hash table engine and its bind.
`include "chained_hash_table_engine_defines.svh"

module cht_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cht_pkg::BCNT_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [cht_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [cht_pkg::S_USER_W-1:0]   s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [cht_pkg::M_DATA_W-1:0]   m_tdata
);
	import cht_pkg::*;

	// A stalled result stays up and unchanged
	`CHT_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid)
	`CHT_ASSERT_NEXT(a_m_stable, m_tvalid && !m_tready, $stable(m_tdata))
	// One item in work at a time: no accept right after an accept
	`CHT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
	// A hit and a dropped insert never come together
	`CHT_ASSERT_NOW(a_hit_or_drop, m_tvalid, !(m_tdata[0] && m_tdata[33]))
	// A miss carries a zero value
	`CHT_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0)

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (.*);
